// ===== hw/rtl/grid_dfs_path_finder_assert.svh =====
// Assertion macros for the grid path finder.
`ifndef GRID_DFS_PATH_FINDER_ASSERT_SVH
`define GRID_DFS_PATH_FINDER_ASSERT_SVH

// The antecedent is checked at every clock edge, outside reset.
`define GDP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent is checked at one edge and the consequent at the next.
`define GDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gdp_pkg.sv =====
`timescale 1ns / 1ps
package gdp_pkg;
  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int Cells = MaxWidth * MaxHeight;
  localparam int AW = XW + YW;
  localparam int CW = AW + 1;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FOUND = 2'd1,
    ST_NOPATH = 2'd2,
    ST_NOSTART = 2'd3
  } status_t;

  // parent marks
  typedef enum logic [2:0] {
    PM_NONE = 3'd0,
    PM_UP = 3'd1,
    PM_DOWN = 3'd2,
    PM_LEFT = 3'd3,
    PM_RIGHT = 3'd4,
    PM_START = 3'd5
  } pmark_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WRITE,
    S_READ0,
    S_READ1,
    S_CHECK,
    S_CLEAR,
    S_INIT,
    S_POP,
    S_POPWAIT,
    S_EXAM,
    S_NBR_RD,
    S_NBR_WAIT,
    S_NBR_DO,
    S_CNT_RD,
    S_CNT_WAIT,
    S_CNT_DO,
    S_BLD_RD,
    S_BLD_WAIT,
    S_BLD_DO,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    wall_we;
    logic    route_rd;
    logic    cfg_check;
    logic    clr_init;
    logic    clr_step;
    logic    push_start;
    logic    pop_rd;
    logic    pop_take;
    logic    dir_init;
    logic    nbr_rd;
    logic    nbr_do;
    logic    walk_init;
    logic    walk_rd;
    logic    cnt_do;
    logic    bld_init;
    logic    bld_do;
    logic    finish;
    status_t stat;
  } ctl_t;

  typedef struct packed {
    logic bad_cfg;
    logic clr_last;
    logic stack_empty;
    logic at_goal;
    logic dir_last;
    logic at_start;
    logic bld_last;
  } sts_t;
endpackage

// ===== hw/rtl/grid_dfs_path_finder.sv =====
`timescale 1ns / 1ps
// Grid path finder: a depth-first search over a 4-connected wall map of up to
// 64 x 64 cells. An item is taken at a clock edge where start is high and busy
// is low; every item gives exactly one result, shown for one cycle with
// out_valid high in the last busy cycle, and the receiver cannot stall it.
// A cell write or the unused mode answers after the write state, a path read
// after one memory read. A search clears the 4096-entry parent store first,
// then pops one cell at a time and tests its four neighbors in turn, then
// walks the parent marks twice to count and store the path. All of it runs
// through one read port on each memory, which sets the pace. A search with an
// unset or out-of-grid origin or goal answers straight after the check state.
module grid_dfs_path_finder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_cell_x,
  input  logic [5:0]  in_cell_y,
  input  logic        in_is_wall,
  input  logic [11:0] in_path_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [12:0] out_path_length,
  output logic [5:0]  out_step_x,
  output logic [5:0]  out_step_y,
  output logic        out_entry_valid
);
  `include "grid_dfs_path_finder_assert.svh"

  typedef enum logic [2:0] {
    REG_WIDTH = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_OX = 3'd2,
    REG_OY = 3'd3,
    REG_GX = 3'd4,
    REG_GY = 3'd5
  } reg_idx_t;

  logic [6:0] w_r, h_r, ox_r, oy_r, gx_r, gy_r;

  // configuration is always taken
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 7'd64;
      h_r <= 7'd64;
      ox_r <= 7'h7f;
      oy_r <= 7'h7f;
      gx_r <= 7'h7f;
      gy_r <= 7'h7f;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  w_r <= cfg_data;
        REG_HEIGHT: h_r <= cfg_data;
        REG_OX:     ox_r <= cfg_data;
        REG_OY:     oy_r <= cfg_data;
        REG_GX:     gx_r <= cfg_data;
        REG_GY:     gy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gdp_pkg::ctl_t ctl;
  gdp_pkg::sts_t sts;
  logic          ctrl_busy;
  logic          valid_pre;

  gdp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_mode(in_mode),
    .sts(sts), .busy(ctrl_busy), .ctl(ctl)
  );

  gdp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(ctrl_busy),
    .in_mode(in_mode), .in_cell_x(in_cell_x), .in_cell_y(in_cell_y),
    .in_is_wall(in_is_wall), .in_path_index(in_path_index),
    .w_cfg(w_r), .h_cfg(h_r), .ox_cfg(ox_r), .oy_cfg(oy_r),
    .gx_cfg(gx_r), .gy_cfg(gy_r), .ctl(ctl), .sts(sts),
    .out_valid_nxt(valid_pre), .out_status(out_status),
    .out_path_length(out_path_length), .out_step_x(out_step_x),
    .out_step_y(out_step_y), .out_entry_valid(out_entry_valid)
  );

  assign busy = ctrl_busy;
  assign out_valid = valid_pre;

  // every result falls in a busy cycle, after which the block is free
  `GDP_ASSERT_IMP(a_valid_busy, out_valid, busy, "result outside an item")
  `GDP_ASSERT_NEXT(a_valid_idle, out_valid, !busy, "block stays busy after result")
  `GDP_ASSERT_IMP(a_entry_mode, out_valid && out_entry_valid,
                  out_status == gdp_pkg::ST_DONE, "path entry with search status")
endmodule

// ===== hw/rtl/gdp_ctrl.sv =====
`timescale 1ns / 1ps
module gdp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_mode,
  input  gdp_pkg::sts_t    sts,
  output logic             busy,
  output gdp_pkg::ctl_t    ctl
);
  gdp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gdp_pkg::S_IDLE: begin
        if (start) begin
          unique case (in_mode)
            gdp_pkg::MODE_SEARCH: state_nxt = gdp_pkg::S_CHECK;
            gdp_pkg::MODE_READ:   state_nxt = gdp_pkg::S_READ0;
            default:              state_nxt = gdp_pkg::S_WRITE;
          endcase
        end
      end
      gdp_pkg::S_WRITE:    state_nxt = gdp_pkg::S_RESP;
      gdp_pkg::S_READ0:    state_nxt = gdp_pkg::S_READ1;
      gdp_pkg::S_READ1:    state_nxt = gdp_pkg::S_RESP;
      gdp_pkg::S_CHECK:    state_nxt = sts.bad_cfg ? gdp_pkg::S_RESP : gdp_pkg::S_CLEAR;
      gdp_pkg::S_CLEAR:    if (sts.clr_last) state_nxt = gdp_pkg::S_INIT;
      gdp_pkg::S_INIT:     state_nxt = gdp_pkg::S_POP;
      gdp_pkg::S_POP:      state_nxt = sts.stack_empty ? gdp_pkg::S_RESP : gdp_pkg::S_POPWAIT;
      gdp_pkg::S_POPWAIT:  state_nxt = gdp_pkg::S_EXAM;
      gdp_pkg::S_EXAM:     state_nxt = sts.at_goal ? gdp_pkg::S_CNT_RD : gdp_pkg::S_NBR_RD;
      gdp_pkg::S_NBR_RD:   state_nxt = gdp_pkg::S_NBR_WAIT;
      gdp_pkg::S_NBR_WAIT: state_nxt = gdp_pkg::S_NBR_DO;
      gdp_pkg::S_NBR_DO:   state_nxt = sts.dir_last ? gdp_pkg::S_POP : gdp_pkg::S_NBR_RD;
      gdp_pkg::S_CNT_RD:   state_nxt = sts.at_start ? gdp_pkg::S_BLD_RD : gdp_pkg::S_CNT_WAIT;
      gdp_pkg::S_CNT_WAIT: state_nxt = gdp_pkg::S_CNT_DO;
      gdp_pkg::S_CNT_DO:   state_nxt = gdp_pkg::S_CNT_RD;
      gdp_pkg::S_BLD_RD:   state_nxt = gdp_pkg::S_BLD_WAIT;
      gdp_pkg::S_BLD_WAIT: state_nxt = gdp_pkg::S_BLD_DO;
      gdp_pkg::S_BLD_DO:   state_nxt = sts.bld_last ? gdp_pkg::S_RESP : gdp_pkg::S_BLD_RD;
      gdp_pkg::S_RESP:     state_nxt = gdp_pkg::S_IDLE;
      default:             state_nxt = gdp_pkg::S_IDLE;
    endcase
  end

  // status of the reply is latched by the datapath on finish
  always_comb begin
    ctl = '0;
    ctl.stat = gdp_pkg::ST_DONE;
    busy = (state_r != gdp_pkg::S_IDLE);
    unique case (state_r)
      gdp_pkg::S_IDLE: ;
      gdp_pkg::S_WRITE: begin
        ctl.wall_we = 1'b1;
        ctl.finish = 1'b1;
      end
      gdp_pkg::S_READ0: ctl.route_rd = 1'b1;
      gdp_pkg::S_READ1: ctl.finish = 1'b1;
      gdp_pkg::S_CHECK: begin
        ctl.cfg_check = 1'b1;
        ctl.clr_init = 1'b1;
        ctl.stat = gdp_pkg::ST_NOSTART;
        ctl.finish = sts.bad_cfg;
      end
      gdp_pkg::S_CLEAR: ctl.clr_step = 1'b1;
      gdp_pkg::S_INIT: ctl.push_start = 1'b1;
      gdp_pkg::S_POP: begin
        ctl.pop_rd = 1'b1;
        ctl.stat = gdp_pkg::ST_NOPATH;
        ctl.finish = sts.stack_empty;
      end
      gdp_pkg::S_POPWAIT: ctl.pop_take = 1'b1;
      gdp_pkg::S_EXAM: begin
        ctl.dir_init = 1'b1;
        ctl.walk_init = 1'b1;
      end
      gdp_pkg::S_NBR_RD: ctl.nbr_rd = 1'b1;
      gdp_pkg::S_NBR_WAIT: ;
      gdp_pkg::S_NBR_DO: ctl.nbr_do = 1'b1;
      gdp_pkg::S_CNT_RD: begin
        ctl.walk_rd = 1'b1;
        ctl.bld_init = sts.at_start;
      end
      // hold the parent store address on the walk cell
      gdp_pkg::S_CNT_WAIT: ctl.walk_rd = 1'b1;
      gdp_pkg::S_CNT_DO: ctl.cnt_do = 1'b1;
      gdp_pkg::S_BLD_RD: ctl.walk_rd = 1'b1;
      gdp_pkg::S_BLD_WAIT: ctl.walk_rd = 1'b1;
      gdp_pkg::S_BLD_DO: begin
        ctl.bld_do = 1'b1;
        ctl.stat = gdp_pkg::ST_FOUND;
        ctl.finish = sts.bld_last;
      end
      gdp_pkg::S_RESP: ;
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/gdp_datapath.sv =====
`timescale 1ns / 1ps
module gdp_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       in_mode,
  input  logic [5:0]       in_cell_x,
  input  logic [5:0]       in_cell_y,
  input  logic             in_is_wall,
  input  logic [11:0]      in_path_index,
  input  logic [6:0]       w_cfg,
  input  logic [6:0]       h_cfg,
  input  logic [6:0]       ox_cfg,
  input  logic [6:0]       oy_cfg,
  input  logic [6:0]       gx_cfg,
  input  logic [6:0]       gy_cfg,
  input  gdp_pkg::ctl_t    ctl,
  output gdp_pkg::sts_t    sts,
  output logic             out_valid_nxt,
  output logic [1:0]       out_status,
  output logic [12:0]      out_path_length,
  output logic [5:0]       out_step_x,
  output logic [5:0]       out_step_y,
  output logic             out_entry_valid
);
  localparam int XW = gdp_pkg::XW;
  localparam int YW = gdp_pkg::YW;
  localparam int AW = gdp_pkg::AW;
  localparam int CW = gdp_pkg::CW;

  // memories
  logic          wall_mem [gdp_pkg::Cells];
  logic [2:0]    vp_mem   [gdp_pkg::Cells];
  gdp_pkg::addr_t stk_mem [gdp_pkg::Cells];
  gdp_pkg::addr_t rt_mem  [gdp_pkg::Cells];

  // latched item
  logic [1:0]  mode_r;
  logic [XW-1:0] cx_r;
  logic [YW-1:0] cy_r;
  logic        wall_r;
  logic [11:0] pidx_r;

  logic [XW:0] w_r;
  logic [YW:0] h_r;
  gdp_pkg::addr_t s_r, g_r, cur_r, nb_r, walk_r;
  gdp_pkg::cnt_t  top_r, clr_r, len_r, rlen_r, k_r;
  logic [2:0]  dir_r;
  logic        wall_q, rd_ok_r;
  logic [2:0]  vp_q;
  gdp_pkg::addr_t stk_q, rt_q;
  logic [1:0]  stat_r;

  // clamped size
  logic [XW:0] w_cl;
  logic [YW:0] h_cl;
  always_comb begin
    if (w_cfg == '0) w_cl = (XW+1)'(1);
    else if (w_cfg > 7'(gdp_pkg::MaxWidth)) w_cl = (XW+1)'(gdp_pkg::MaxWidth);
    else w_cl = w_cfg[XW:0];
    if (h_cfg == '0) h_cl = (YW+1)'(1);
    else if (h_cfg > 7'(gdp_pkg::MaxHeight)) h_cl = (YW+1)'(gdp_pkg::MaxHeight);
    else h_cl = h_cfg[YW:0];
  end

  logic bad;
  assign bad = ox_cfg[6] || oy_cfg[6] || gx_cfg[6] || gy_cfg[6] ||
               ({1'b0, ox_cfg} >= 8'(w_cl)) || ({1'b0, oy_cfg} >= 8'(h_cl)) ||
               ({1'b0, gx_cfg} >= 8'(w_cl)) || ({1'b0, gy_cfg} >= 8'(h_cl));

  // neighbor of the current cell for dir_r
  logic [XW-1:0] ccx;
  logic [YW-1:0] ccy;
  logic          nb_ok;
  gdp_pkg::addr_t nb;
  assign ccx = cur_r[XW-1:0];
  assign ccy = cur_r[AW-1:XW];
  always_comb begin
    nb_ok = 1'b0;
    nb = cur_r;
    case (dir_r)
      gdp_pkg::PM_UP: begin
        nb_ok = (ccy != '0);
        nb = {ccy - YW'(1), ccx};
      end
      gdp_pkg::PM_DOWN: begin
        nb_ok = ((YW+1)'(ccy) + (YW+1)'(1) < h_r);
        nb = {ccy + YW'(1), ccx};
      end
      gdp_pkg::PM_LEFT: begin
        nb_ok = (ccx != '0);
        nb = {ccy, ccx - XW'(1)};
      end
      gdp_pkg::PM_RIGHT: begin
        nb_ok = ((XW+1)'(ccx) + (XW+1)'(1) < w_r);
        nb = {ccy, ccx + XW'(1)};
      end
      default: ;
    endcase
  end

  // step back along the parent mark
  gdp_pkg::addr_t back;
  always_comb begin
    back = walk_r;
    case (vp_q)
      gdp_pkg::PM_UP:    back = {walk_r[AW-1:XW] + YW'(1), walk_r[XW-1:0]};
      gdp_pkg::PM_DOWN:  back = {walk_r[AW-1:XW] - YW'(1), walk_r[XW-1:0]};
      gdp_pkg::PM_LEFT:  back = {walk_r[AW-1:XW], walk_r[XW-1:0] + XW'(1)};
      gdp_pkg::PM_RIGHT: back = {walk_r[AW-1:XW], walk_r[XW-1:0] - XW'(1)};
      default: ;
    endcase
  end

  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      cx_r <= in_cell_x[XW-1:0];
      cy_r <= in_cell_y[YW-1:0];
      wall_r <= in_is_wall;
      pidx_r <= in_path_index;
    end
    if (ctl.cfg_check) begin
      w_r <= w_cl;
      h_r <= h_cl;
      s_r <= {oy_cfg[YW-1:0], ox_cfg[XW-1:0]};
      g_r <= {gy_cfg[YW-1:0], gx_cfg[XW-1:0]};
    end
  end

  // wall map port; the unused mode passes through the write state untouched
  gdp_pkg::addr_t wall_ra;
  assign wall_ra = nb;
  always_ff @(posedge clk) begin
    if (ctl.wall_we && mode_r == gdp_pkg::MODE_WRITE) wall_mem[{cy_r, cx_r}] <= wall_r;
    wall_q <= wall_mem[wall_ra];
  end

  // visit/parent store: one write, one read per cycle
  logic           vp_we;
  gdp_pkg::addr_t vp_wa, vp_ra;
  logic [2:0]     vp_wd;
  always_comb begin
    vp_we = 1'b0;
    vp_wa = clr_r[AW-1:0];
    vp_wd = gdp_pkg::PM_NONE;
    if (ctl.clr_step) begin
      vp_we = 1'b1;
    end else if (ctl.push_start) begin
      vp_we = 1'b1;
      vp_wa = s_r;
      vp_wd = gdp_pkg::PM_START;
    end else if (ctl.nbr_do && nb_ok && vp_q == gdp_pkg::PM_NONE && !wall_q) begin
      vp_we = 1'b1;
      vp_wa = nb_r;
      vp_wd = dir_r;
    end
    vp_ra = (ctl.walk_rd) ? walk_r : nb;
  end
  always_ff @(posedge clk) begin
    if (vp_we) vp_mem[vp_wa] <= vp_wd;
    vp_q <= vp_mem[vp_ra];
  end

  logic push_nb;
  assign push_nb = ctl.nbr_do && nb_ok && vp_q == gdp_pkg::PM_NONE && !wall_q &&
                   top_r < CW'(gdp_pkg::Cells);

  // stack memory
  always_ff @(posedge clk) begin
    if (ctl.push_start) stk_mem[0] <= s_r;
    else if (push_nb) stk_mem[top_r[AW-1:0]] <= nb_r;
    stk_q <= stk_mem[top_r[AW-1:0] - AW'(1)];
  end

  // route store
  always_ff @(posedge clk) begin
    if (ctl.bld_do) rt_mem[k_r[AW-1:0] - AW'(1)] <= walk_r;
    rt_q <= rt_mem[pidx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      rlen_r <= '0;
    end else begin
      if (ctl.push_start) top_r <= CW'(1);
      else if (ctl.pop_rd && top_r != '0) top_r <= top_r - CW'(1);
      else if (push_nb) top_r <= top_r + CW'(1);
      if (ctl.bld_init) rlen_r <= len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_init) clr_r <= '0;
    else if (ctl.clr_step) clr_r <= clr_r + CW'(1);
    if (ctl.pop_take) cur_r <= stk_q;
    if (ctl.dir_init) dir_r <= gdp_pkg::PM_UP;
    else if (ctl.nbr_do) dir_r <= dir_r + 3'd1;
    if (ctl.nbr_rd) nb_r <= nb;
    if (ctl.walk_init) begin
      walk_r <= g_r;
      len_r <= CW'(1);
    end else if (ctl.cnt_do) begin
      // parent walk ends early on a missing mark
      if (vp_q >= gdp_pkg::PM_UP && vp_q <= gdp_pkg::PM_RIGHT) begin
        walk_r <= back;
        len_r <= len_r + CW'(1);
      end else begin
        walk_r <= s_r;
      end
    end else if (ctl.bld_init) begin
      walk_r <= g_r;
    end else if (ctl.bld_do) begin
      walk_r <= back;
    end
    if (ctl.bld_init) k_r <= len_r;
    else if (ctl.bld_do) k_r <= k_r - CW'(1);
    if (ctl.route_rd) rd_ok_r <= ({1'b0, pidx_r} < rlen_r);
    if (ctl.finish) stat_r <= ctl.stat;
    else if (accept) stat_r <= gdp_pkg::ST_DONE;
  end

  assign sts.bad_cfg = bad;
  assign sts.clr_last = (clr_r == CW'(gdp_pkg::Cells - 1));
  assign sts.stack_empty = (top_r == '0);
  assign sts.at_goal = (cur_r == g_r);
  assign sts.dir_last = (dir_r == gdp_pkg::PM_RIGHT);
  assign sts.at_start = (walk_r == s_r);
  assign sts.bld_last = (k_r == CW'(1));

  // reply fields, shown in the response cycle
  logic resp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) resp_r <= 1'b0;
    else resp_r <= ctl.finish;
  end
  assign out_valid_nxt = resp_r;
  assign out_status = stat_r;
  assign out_path_length = 13'(rlen_r);
  logic show;
  assign show = (mode_r == gdp_pkg::MODE_READ) && rd_ok_r;
  assign out_entry_valid = show;
  assign out_step_x = show ? 6'(rt_q[XW-1:0]) : '0;
  assign out_step_y = show ? 6'(rt_q[AW-1:XW]) : '0;
endmodule
